>>> design/binary_erosion_3x3_defines.svh
// Assertion macros used by the erosion back end.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef BINARY_EROSION_3X3_DEFINES_SVH
`define BINARY_EROSION_3X3_DEFINES_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define BERO_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BERO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/bero_pkg.sv
// Shared types, constants and the structuring element table for the erosion block.
// No dependencies.
package bero_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_HEIGHT   = 4096;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ROW_W        = 13;
	localparam int CH_W         = 8;
	localparam int PIX_W        = 3 * CH_W;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 13;
	localparam int QDEPTH       = 4;
	localparam int QPTR_W       = $clog2(QDEPTH);
	localparam int QCNT_W       = QPTR_W + 1;

	localparam logic [CH_W-1:0] WHITE = 8'hFF;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	typedef enum logic [1:0] {
		MODE_RIGHT,
		MODE_BELOW,
		MODE_SQUARE,
		MODE_CROSS
	} mode_t;

	// One classified item as it travels from the front to the back.
	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic [COL_W-1:0] col;
		logic             emit;
		logic             interior;
		logic             last;
	} bero_item_t;

	// Window taps, bit k: 0..2 top row, 3..5 middle row, 6..8 bottom row.
	function automatic logic [8:0] element_mask(mode_t m);
		logic [8:0] mask;
		unique case (m)
			MODE_RIGHT:  mask = 9'h030;
			MODE_BELOW:  mask = 9'h090;
			MODE_SQUARE: mask = 9'h1FF;
			MODE_CROSS:  mask = 9'h0BA;
		endcase
		return mask;
	endfunction

endpackage

>>> design/bero_front.sv
// Front end: accepts items, tracks column and row, drops out-of-phase items
// and tags each kept item for the back end. Depends on bero_pkg.
module bero_front
	import bero_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    restart,
	input  logic [WIDTH_REG_W-1:0]  width_q,
	input  logic [HEIGHT_REG_W-1:0] height_q,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [PIX_W-1:0]        s_axis_tdata,   // in_chan0, in_chan1, in_chan2
	input  logic                    s_axis_tuser,   // operation
	input  logic                    q_full,
	output logic                    push,
	output bero_item_t              push_item
);

	logic [COL_W-1:0]        col_q;
	logic [ROW_W-1:0]        row_q;
	logic [WIDTH_REG_W-1:0]  w_cl;
	logic [HEIGHT_REG_W-1:0] h_cl;
	logic [COL_W-1:0]        w_m1;
	logic [ROW_W:0]          h_p1;
	logic                    done;
	logic                    drain;
	logic                    emit;
	logic                    interior;
	logic                    last;
	logic                    wrap;

	always_comb begin
		if (width_q < WIDTH_REG_W'(3)) begin
			w_cl = WIDTH_REG_W'(3);
		end else if (width_q > WIDTH_REG_W'(MAX_WIDTH)) begin
			w_cl = WIDTH_REG_W'(MAX_WIDTH);
		end else begin
			w_cl = width_q;
		end
		if (height_q < HEIGHT_REG_W'(3)) begin
			h_cl = HEIGHT_REG_W'(3);
		end else if (height_q > HEIGHT_REG_W'(MAX_HEIGHT)) begin
			h_cl = HEIGHT_REG_W'(MAX_HEIGHT);
		end else begin
			h_cl = height_q;
		end
	end

	assign w_m1 = COL_W'(w_cl - WIDTH_REG_W'(1));
	assign h_p1 = (ROW_W+1)'(h_cl) + (ROW_W+1)'(1);

	assign done     = row_q >= ROW_W'(h_cl);
	assign drain    = (s_axis_tuser == OP_DRAIN);
	assign emit     = (row_q >= ROW_W'(2)) || (row_q == ROW_W'(1) && col_q != '0);
	assign interior = (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2)) && !done;
	// Result count reaches width*height exactly at column 0 of row height+1.
	assign last     = ((ROW_W+1)'(row_q) == h_p1) && (col_q == '0);
	assign wrap     = (col_q == w_m1);

	assign s_axis_tready = !q_full;
	// Drop a drain item before the frame is in and a pixel item while draining.
	assign push          = s_axis_tvalid && s_axis_tready && (drain == done);

	assign push_item.pix      = drain ? '0 : s_axis_tdata;
	assign push_item.col      = col_q;
	assign push_item.emit     = emit;
	assign push_item.interior = interior;
	assign push_item.last     = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule

>>> design/bero_queue.sv
// Short FIFO between front and back end, so either side can stall alone.
// Depends on bero_pkg.
module bero_queue
	import bero_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  bero_item_t push_item,
	output logic       full,
	input  logic       pop,
	output logic       valid,
	output bero_item_t head
);

	bero_item_t        slots_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QDEPTH));
	assign valid = (count_q != '0);
	assign head  = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> design/bero_back.sv
// Back end: line stores, 3x3 window, erosion decision and output register.
// Depends on bero_pkg and binary_erosion_3x3_defines.svh.
`include "binary_erosion_3x3_defines.svh"
module bero_back
	import bero_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  mode_t            mode,
	input  logic             q_valid,
	input  bero_item_t       q_item,
	output logic             q_pop,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [PIX_W-1:0] m_axis_tdata,   // out_chan0, out_chan1, out_chan2
	output logic             m_axis_tlast    // frame_last
);

	logic [CH_W-1:0]  up_mem  [MAX_WIDTH];
	logic [PIX_W-1:0] mid_mem [MAX_WIDTH];

	logic             adv;
	logic             v_s1;
	logic             v_s2;
	bero_item_t       item_s1;
	bero_item_t       item_s2;
	logic [CH_W-1:0]  up_s2;
	logic [PIX_W-1:0] mid_s2;
	logic             fwd;
	logic [CH_W-1:0]  win_q [6];
	logic [PIX_W-1:0] held_q;
	logic [CH_W-1:0]  vals [9];
	logic [8:0]       mask;
	logic             hit;
	logic [PIX_W-1:0] res;
	logic             ov_q;
	logic [PIX_W-1:0] odata_q;
	logic             olast_q;

	// The whole back end moves in lockstep whenever the output slot can take a result.
	assign adv   = !ov_q || m_axis_tready;
	assign q_pop = adv && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			ov_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			ov_q <= v_s2 && item_s2.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= q_item;
			item_s2 <= item_s1;
		end
	end

	// Column reused one item apart across a frame boundary: bypass the pending write.
	assign fwd = v_s2 && (item_s2.col == item_s1.col);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (v_s2) begin
				up_mem[item_s2.col]  <= mid_s2[CH_W-1:0];
				mid_mem[item_s2.col] <= item_s2.pix;
			end
			up_s2  <= fwd ? mid_s2[CH_W-1:0] : up_mem[item_s1.col];
			mid_s2 <= fwd ? item_s2.pix : mid_mem[item_s1.col];
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= up_s2;
			win_q[4] <= mid_s2[CH_W-1:0];
			win_q[5] <= item_s2.pix[CH_W-1:0];
			held_q   <= mid_s2;
		end
	end

	always_comb begin
		vals[0] = win_q[0];
		vals[1] = win_q[3];
		vals[2] = up_s2;
		vals[3] = win_q[1];
		vals[4] = win_q[4];
		vals[5] = mid_s2[CH_W-1:0];
		vals[6] = win_q[2];
		vals[7] = win_q[5];
		vals[8] = item_s2.pix[CH_W-1:0];
		mask    = element_mask(mode);
		hit     = 1'b0;
		for (int k = 0; k < 9; k++) begin
			if (mask[k] && vals[k] != WHITE) begin
				hit = 1'b1;
			end
		end
		if (item_s2.interior) begin
			res = hit ? '0 : '1;
		end else begin
			res = held_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			odata_q <= res;
			olast_q <= item_s2.last;
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = odata_q;
	assign m_axis_tlast  = olast_q;

	`BERO_ASSERT_NEXT(a_emit_loads_out, adv && v_s2 && item_s2.emit, ov_q, "emitting item lost")
	`BERO_ASSERT_NOW(a_interior_emits, v_s2 && item_s2.interior, item_s2.emit, "interior without emit")
	`BERO_ASSERT_NOW(a_last_border, v_s2 && item_s2.last, item_s2.emit && !item_s2.interior, "bad frame end")

endmodule

>>> design/binary_erosion_3x3.sv
// 3x3 binary erosion on a raster pixel stream, four structuring elements.
// Throughput: one item per clock unless output or queue stalls; a result is caused by the
// item image_width+1 items after its own pixel (set by the two line stores).
// Drain items after the last pixel flush the final image_width+1 results.
// Reset clears counters and loads mode 2, width 640, height 480; line stores are not cleared.
// Depends on bero_pkg, bero_front, bero_queue, bero_back.
module binary_erosion_3x3
	import bero_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [PIX_W-1:0]      s_axis_tdata,   // in_chan0, in_chan1, in_chan2
	input  logic                  s_axis_tuser,   // operation
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [PIX_W-1:0]      m_axis_tdata,   // out_chan0, out_chan1, out_chan2
	output logic                  m_axis_tlast    // frame_last
);

	mode_t                   mode_q;
	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic                    restart;
	logic                    push;
	bero_item_t              push_item;
	logic                    q_full;
	logic                    q_valid;
	logic                    q_pop;
	bero_item_t              q_item;

	// A size write restarts the frame.
	assign restart = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_SQUARE;
			width_q  <= WIDTH_REG_W'(640);
			height_q <= HEIGHT_REG_W'(480);
		end else if (cfg_we) begin
			if (cfg_index == REG_MODE) begin
				mode_q <= mode_t'(cfg_data[1:0]);
			end
			if (cfg_index == REG_WIDTH) begin
				width_q <= cfg_data[WIDTH_REG_W-1:0];
			end
			if (cfg_index == REG_HEIGHT) begin
				height_q <= cfg_data;
			end
		end
	end

	bero_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.restart       (restart),
		.width_q       (width_q),
		.height_q      (height_q),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.push          (push),
		.push_item     (push_item)
	);

	bero_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_item)
	);

	bero_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.mode          (mode_q),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
